[rtl/stc_pkg.sv]
`timescale 1ns / 1ps

package stc_pkg;

    // fixed field widths
    localparam int CODE_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 9;

    // default character buffer depth
    localparam int DEFAULT_FIFO_DEPTH = 256;

    // opcodes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    // push / pop request into the buffer
    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_req;

    // buffer occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

[rtl/stc_xlate.sv]
`timescale 1ns / 1ps

module stc_xlate (
    input  logic [stc_pkg::CODE_W-1:0] i_code,
    output logic [stc_pkg::CHAR_W-1:0] o_ascii,
    output logic                       o_mapped
);
    import stc_pkg::*;

    // set-1 make codes to lower-case ascii, release codes fall to default
    always_comb begin
        case (i_code)
            8'h1C: o_ascii = 7'h0A;   // enter
            8'h0E: o_ascii = 7'h08;   // backspace
            8'h39: o_ascii = 7'h20;   // space
            // digit row
            8'h02: o_ascii = 7'h31;
            8'h03: o_ascii = 7'h32;
            8'h04: o_ascii = 7'h33;
            8'h05: o_ascii = 7'h34;
            8'h06: o_ascii = 7'h35;
            8'h07: o_ascii = 7'h36;
            8'h08: o_ascii = 7'h37;
            8'h09: o_ascii = 7'h38;
            8'h0A: o_ascii = 7'h39;
            8'h0B: o_ascii = 7'h30;
            8'h0C: o_ascii = 7'h2D;
            8'h0D: o_ascii = 7'h3D;
            // top letter row
            8'h10: o_ascii = 7'h71;
            8'h11: o_ascii = 7'h77;
            8'h12: o_ascii = 7'h65;
            8'h13: o_ascii = 7'h72;
            8'h14: o_ascii = 7'h74;
            8'h15: o_ascii = 7'h79;
            8'h16: o_ascii = 7'h75;
            8'h17: o_ascii = 7'h69;
            8'h18: o_ascii = 7'h6F;
            8'h19: o_ascii = 7'h70;
            8'h1A: o_ascii = 7'h5B;
            8'h1B: o_ascii = 7'h5D;
            // home row
            8'h1E: o_ascii = 7'h61;
            8'h1F: o_ascii = 7'h73;
            8'h20: o_ascii = 7'h64;
            8'h21: o_ascii = 7'h66;
            8'h22: o_ascii = 7'h67;
            8'h23: o_ascii = 7'h68;
            8'h24: o_ascii = 7'h6A;
            8'h25: o_ascii = 7'h6B;
            8'h26: o_ascii = 7'h6C;
            8'h27: o_ascii = 7'h3B;
            8'h28: o_ascii = 7'h27;
            // bottom row
            8'h2C: o_ascii = 7'h7A;
            8'h2D: o_ascii = 7'h78;
            8'h2E: o_ascii = 7'h63;
            8'h2F: o_ascii = 7'h76;
            8'h30: o_ascii = 7'h62;
            8'h31: o_ascii = 7'h6E;
            8'h32: o_ascii = 7'h6D;
            8'h33: o_ascii = 7'h2C;
            8'h34: o_ascii = 7'h2E;
            8'h35: o_ascii = 7'h2F;
            default: o_ascii = '0;
        endcase
    end

    assign o_mapped = (o_ascii != '0);

endmodule

[rtl/stc_fifo.sv]
`timescale 1ns / 1ps

module stc_fifo #(
    parameter int FIFO_DEPTH = stc_pkg::DEFAULT_FIFO_DEPTH,
    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stc_pkg::t_fifo_req         i_req,
    input  logic [stc_pkg::CHAR_W-1:0] i_wr_data,
    output stc_pkg::t_fifo_flags       o_flags,
    output logic [CNT_W-1:0]           o_count_next,
    output logic [stc_pkg::CHAR_W-1:0] o_rd_data
);
    import stc_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FIFO_DEPTH);

    logic [CHAR_W-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [CHAR_W-1:0] r_rd_data;

    assign o_flags.full  = (r_count == CNT_FULL);
    assign o_flags.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_req.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (i_req.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
        if (i_req.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    assign o_rd_data = r_rd_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fifo count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> !o_flags.full)
        else $error("push into full fifo");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pop |-> !o_flags.empty)
        else $error("pop from empty fifo");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.push && !i_req.pop) |=>
            ({1'b0, r_count} == {1'b0, $past(r_count)} + 1'b1))
        else $error("count did not follow push");

endmodule

[rtl/scancode_to_ascii_fifo_core.sv]
`timescale 1ns / 1ps

// Set-1 scancode to ascii translator with a character fifo. Every transaction
// is either a key event (i_opcode low, i_scancode holds the raw byte) or a
// read request (i_opcode high). A transaction is taken on any edge with start
// high; busy never rises, so one transaction per clock is sustained. Each
// transaction gives exactly one result, which passes the input register and
// then the result register: it is shown on the o_ ports with o_strobe high
// for a single cycle. The receiver cannot stall: a result must be captured
// in the cycle that o_strobe is high.
// The fill level reported is the count after that transaction. The character
// store is a single-write, registered-read memory; no clearing pass is needed
// after reset since only written entries are ever read.

module scancode_to_ascii_fifo_core #(
    parameter int FIFO_DEPTH = stc_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [stc_pkg::CODE_W-1:0]   i_scancode,
    output logic                         o_strobe,
    output logic [stc_pkg::CHAR_W-1:0]   o_character,
    output logic [stc_pkg::STATUS_W-1:0] o_status,
    output logic [stc_pkg::FILL_W-1:0]   o_fill_level
);
    import stc_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // input register
    logic              r_in_valid;
    logic              r_in_opcode;
    logic [CODE_W-1:0] r_in_code;

    // translation and fifo control
    logic [CHAR_W-1:0] ascii;
    logic              mapped;
    t_fifo_req         fifo_req;
    t_fifo_flags       fifo_flags;
    logic [CNT_W-1:0]  count_next;
    logic [CHAR_W-1:0] rd_data;
    logic [STATUS_W-1:0] n_status;
    logic [CNT_W+FILL_W-1:0] count_ext;

    // result register
    logic                r_out_valid;
    logic                r_out_read;
    logic [STATUS_W-1:0] r_out_status;
    logic [FILL_W-1:0]   r_out_fill;

    // the core keeps pace with the input every cycle
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in_opcode <= i_opcode;
            r_in_code   <= i_scancode;
        end
    end

    stc_xlate u_xlate (
        .i_code   (r_in_code),
        .o_ascii  (ascii),
        .o_mapped (mapped)
    );

    // decide push / pop and the status for the registered transaction
    always_comb begin
        fifo_req.push = 1'b0;
        fifo_req.pop  = 1'b0;
        n_status      = ST_IGNORED;
        if (r_in_opcode == OP_KEY) begin
            if (!mapped) begin
                n_status = ST_IGNORED;      // release code or unmapped key
            end else if (fifo_flags.full) begin
                n_status = ST_FULL;         // character dropped
            end else begin
                n_status      = ST_STORED;
                fifo_req.push = r_in_valid;
            end
        end else begin
            if (fifo_flags.empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status     = ST_READ;
                fifo_req.pop = r_in_valid;
            end
        end
    end

    stc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (fifo_req),
        .i_wr_data    (ascii),
        .o_flags      (fifo_flags),
        .o_count_next (count_next),
        .o_rd_data    (rd_data)
    );

    // fill level shows the low bits of the count only
    assign count_ext = {{FILL_W{1'b0}}, count_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_read   <= fifo_req.pop;
            r_out_status <= n_status;
            r_out_fill   <= count_ext[FILL_W-1:0];
        end
    end

    // the fifo read data register lines up with the result register
    assign o_strobe     = r_out_valid;
    assign o_character  = r_out_read ? rd_data : '0;
    assign o_status     = r_out_status;
    assign o_fill_level = r_out_fill;

endmodule

[tb/tb_scancode_to_ascii_fifo_core.sv]
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo_core;

    import stc_pkg::*;

    // buffer depth used by the dut instance and by the local copy of the buffer
    localparam int DEPTH = DEFAULT_FIFO_DEPTH;

    // watchdog limit in clock cycles, far beyond the slowest legal run
    localparam int CYCLE_LIMIT = 200000;

    // rough size of the random part of the stimulus
    localparam int RANDOM_ITEMS = 1200;

    // ascii rows of the keyboard, leftmost key first
    localparam logic [8*12-1:0] DIGIT_ROW  = "1234567890-=";
    localparam logic [8*12-1:0] TOP_ROW    = "qwertyuiop[]";
    localparam logic [8*11-1:0] HOME_ROW   = "asdfghjkl;'";
    localparam logic [8*10-1:0] BOTTOM_ROW = "zxcvbnm,./";

    // one input transaction: key event or read request
    typedef struct {
        logic                op;
        logic [CODE_W-1:0]   code;
    } t_keystroke;

    // one result transaction as the dut should show it
    typedef struct {
        logic [CHAR_W-1:0]   ch;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
    } t_fifo_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_opcode;
    logic [CODE_W-1:0]     i_scancode;
    logic                  o_strobe;
    logic [CHAR_W-1:0]     o_character;
    logic [STATUS_W-1:0]   o_status;
    logic [FILL_W-1:0]     o_fill_level;

    // transactions waiting to be sent, and results still owed by the dut
    t_keystroke    keystroke_queue[$];
    t_fifo_outcome fifo_outcomes[$];

    // local copy of the character buffer
    logic [CHAR_W-1:0] char_buf [DEPTH];
    int                rd_idx;
    int                wr_idx;
    int                char_count;

    int total_items;
    int accepted_count;
    int error_count;
    int cycle_count;

    scancode_to_ascii_fifo_core #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_scancode  (i_scancode),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_status    (o_status),
        .o_fill_level(o_fill_level)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // pick one character out of a right-aligned row string
    function automatic logic [CHAR_W-1:0] row_char(logic [8*12-1:0] row, int len, int pos);
        return row[8*(len-1-pos) +: CHAR_W];
    endfunction

    // set-1 make code to lower-case ascii, zero when the key has no mapping
    function automatic logic [CHAR_W-1:0] key_to_ascii(logic [CODE_W-1:0] code);
        if (code == 8'h1C) return 7'h0A;    // enter
        if (code == 8'h0E) return 7'h08;    // backspace
        if (code == 8'h39) return 7'h20;    // space
        if (code >= 8'h02 && code <= 8'h0D) return row_char(DIGIT_ROW, 12, code - 8'h02);
        if (code >= 8'h10 && code <= 8'h1B) return row_char(TOP_ROW, 12, code - 8'h10);
        if (code >= 8'h1E && code <= 8'h28) return row_char(HOME_ROW, 11, code - 8'h1E);
        if (code >= 8'h2C && code <= 8'h35) return row_char(BOTTOM_ROW, 10, code - 8'h2C);
        return '0;
    endfunction

    // apply one accepted transaction to the local buffer and give the result it causes
    function automatic t_fifo_outcome next_fifo_outcome(logic op, logic [CODE_W-1:0] code);
        t_fifo_outcome     res;
        logic [CHAR_W-1:0] ascii;
        res.ch = '0;
        if (op == OP_KEY) begin
            // release codes have bit 7 set and never map
            ascii = code[7] ? '0 : key_to_ascii(code);
            if (ascii == '0) begin
                res.status = ST_IGNORED;
            end else if (char_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                char_buf[wr_idx] = ascii;
                wr_idx = (wr_idx + 1 >= DEPTH) ? 0 : wr_idx + 1;
                char_count++;
                res.status = ST_STORED;
            end
        end else begin
            if (char_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.ch = char_buf[rd_idx];
                rd_idx = (rd_idx + 1 >= DEPTH) ? 0 : rd_idx + 1;
                char_count--;
                res.status = ST_READ;
            end
        end
        res.fill = char_count[FILL_W-1:0];
        return res;
    endfunction

    // random make code that has an ascii mapping
    function automatic logic [CODE_W-1:0] random_mapped_code();
        int sel;
        sel = $urandom_range(0, 47);
        if (sel == 0) return 8'h1C;
        if (sel == 1) return 8'h0E;
        if (sel == 2) return 8'h39;
        if (sel < 15) return 8'h02 + sel - 3;
        if (sel < 27) return 8'h10 + sel - 15;
        if (sel < 38) return 8'h1E + sel - 27;
        return 8'h2C + sel - 38;
    endfunction

    task automatic add_item(logic op, logic [CODE_W-1:0] code);
        t_keystroke item;
        item.op   = op;
        item.code = code;
        keystroke_queue.push_back(item);
    endtask

    // key press with random content: a make code, sometimes followed by its release
    task automatic add_key_press();
        logic [CODE_W-1:0] code;
        code = random_mapped_code();
        add_item(OP_KEY, code);
        if ($urandom_range(0, 3) == 0) add_item(OP_KEY, code | 8'h80);
    endtask

    // anything at all: either opcode, any byte
    task automatic add_noise();
        add_item(logic'($urandom_range(0, 1)), CODE_W'($urandom_range(0, 255)));
    endtask

    task automatic add_read();
        add_item(OP_READ, CODE_W'($urandom_range(0, 255)));
    endtask

    // burst that mostly types keys, pushing the buffer toward full
    task automatic add_fill_burst(int len);
        repeat (len) begin
            if ($urandom_range(0, 99) < 93) add_key_press();
            else add_noise();
        end
    endtask

    // burst that mostly reads, draining the buffer toward empty
    task automatic add_drain_burst(int len);
        repeat (len) begin
            if ($urandom_range(0, 99) < 93) add_read();
            else add_noise();
        end
    endtask

    task automatic build_stimulus();
        int kind;
        // directed part: empty read, releases, every mapping boundary, unmapped gaps
        add_item(OP_READ, 8'h00);
        add_item(OP_KEY, 8'h80);
        add_item(OP_KEY, 8'hFF);
        add_item(OP_KEY, 8'h9C);
        add_item(OP_KEY, 8'h00);
        add_item(OP_KEY, 8'h01);
        add_item(OP_KEY, 8'h7F);
        add_item(OP_KEY, 8'h1C);
        add_item(OP_KEY, 8'h0E);
        add_item(OP_KEY, 8'h39);
        add_item(OP_KEY, 8'h02);
        add_item(OP_KEY, 8'h0D);
        add_item(OP_KEY, 8'h0F);
        add_item(OP_KEY, 8'h10);
        add_item(OP_KEY, 8'h1B);
        add_item(OP_KEY, 8'h1D);
        add_item(OP_KEY, 8'h1E);
        add_item(OP_KEY, 8'h28);
        add_item(OP_KEY, 8'h29);
        add_item(OP_KEY, 8'h2B);
        add_item(OP_KEY, 8'h2C);
        add_item(OP_KEY, 8'h35);
        add_item(OP_KEY, 8'h36);
        add_item(OP_READ, 8'hFF);
        add_item(OP_READ, 8'h5A);

        // random part: first a fill past full so drops and pointer wrap occur,
        // then a drain past empty, then a shuffle of burst kinds
        add_fill_burst(300);
        add_drain_burst(300);
        while (keystroke_queue.size() < RANDOM_ITEMS + 25) begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: begin
                    add_fill_burst($urandom_range(20, 120));
                end
                1: begin
                    add_drain_burst($urandom_range(20, 120));
                end
                2: begin
                    repeat ($urandom_range(20, 60)) begin
                        if ($urandom_range(0, 1) == 0) add_key_press();
                        else add_read();
                    end
                end
                default: begin
                    repeat ($urandom_range(5, 20)) add_noise();
                end
            endcase
        end
        total_items = keystroke_queue.size();
    endtask

    // sender idle rate by phase: 29 percent, then 64 percent, then none
    function automatic int idle_percent();
        if (accepted_count < total_items / 3) return 29;
        if (accepted_count < 2 * total_items / 3) return 64;
        return 0;
    endfunction

    // driver: a transaction moves on an edge with start high and busy low;
    // the prediction is made right there, at the accepting edge
    always @(posedge i_clk) begin
        logic accepted;
        logic send_next;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                fifo_outcomes.push_back(next_fifo_outcome(i_opcode, i_scancode));
                accepted_count++;
                void'(keystroke_queue.pop_front());
            end
            if (start && !accepted) begin
                // held off by busy: keep the same transaction on the ports
            end else begin
                send_next = keystroke_queue.size() != 0 &&
                            $urandom_range(0, 99) >= idle_percent();
                if (send_next) begin
                    start      <= 1'b1;
                    i_opcode   <= keystroke_queue[0].op;
                    i_scancode <= keystroke_queue[0].code;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe is one result, matched against the oldest prediction
    always @(posedge i_clk) begin
        t_fifo_outcome want;
        if (i_rst_n && o_strobe) begin
            if (fifo_outcomes.size() == 0) begin
                $display("%0t: unexpected result character %h status %0d fill %0d",
                         $time, o_character, o_status, o_fill_level);
                error_count++;
            end else begin
                want = fifo_outcomes.pop_front();
                if (o_character !== want.ch) begin
                    $display("%0t: character mismatch expected %h actual %h",
                             $time, want.ch, o_character);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_fill_level !== want.fill) begin
                    $display("%0t: fill level mismatch expected %0d actual %0d",
                             $time, want.fill, o_fill_level);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("scancode_to_ascii_fifo_core verification failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_KEY;
        i_scancode     = '0;
        rd_idx         = 0;
        wr_idx         = 0;
        char_count     = 0;
        accepted_count = 0;
        error_count    = 0;
        cycle_count    = 0;
        build_stimulus();

        // single reset at the start of the run
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every transaction sent, then every result back, then a wait
        // to catch any stray strobe
        while (keystroke_queue.size() != 0 || start) @(posedge i_clk);
        while (fifo_outcomes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("scancode_to_ascii_fifo_core verification clean");
        end else begin
            $display("scancode_to_ascii_fifo_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/stc_pkg.sv
rtl/stc_xlate.sv
rtl/stc_fifo.sv
rtl/scancode_to_ascii_fifo_core.sv
tb/tb_scancode_to_ascii_fifo_core.sv
